// ===== hw/rtl/fba_pkg.sv =====
package fba_pkg;

    // fixed field widths
    localparam int OP_W     = 1;
    localparam int EIDX_W   = 4;
    localparam int AMT_W    = 16;
    localparam int STAT_W   = 2;
    localparam int MODE_W   = 2;
    localparam int BC_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam int DEF_NUM_BLOCKS = 16;
    localparam int DEF_SIZE_WIDTH = 16;

    localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
    localparam logic [OP_W-1:0] OP_ALLOC = 1'b1;

    localparam logic [STAT_W-1:0] STAT_LOADED  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ALLOC   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOALLOC = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    localparam logic [BC_W-1:0] BC_RESET = 5'd16;

    typedef struct packed {
        logic capture;   // input transfer this cycle
        logic rd_issue;  // read table at scan address, advance
        logic finish;    // write back and load result register
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op_in;
        logic            limit_zero;
        logic            addr_last;
    } dp_status_t;

endpackage

// ===== hw/rtl/fba_ctrl.sv =====
module fba_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  fba_pkg::dp_status_t st,
    output fba_pkg::dp_cmd_t    cmd
);
    import fba_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.rd_issue = 1'b0;
        cmd.finish   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (st.op_in == OP_LOAD || st.limit_zero)
                        state_next = S_FINISH;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd_issue = 1'b1;
                if (st.addr_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                // last read data is evaluated here
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/fba_dp.sv =====
module fba_dp
#(
    parameter int NUM_BLOCKS = fba_pkg::DEF_NUM_BLOCKS,
    parameter int SIZE_WIDTH = fba_pkg::DEF_SIZE_WIDTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fba_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [fba_pkg::OP_W-1:0]          op,
    input  logic [fba_pkg::EIDX_W-1:0]        entry_index,
    input  logic [fba_pkg::AMT_W-1:0]         amount,
    output logic [fba_pkg::STAT_W-1:0]        status,
    output logic [fba_pkg::EIDX_W-1:0]        chosen_index,
    output logic [fba_pkg::AMT_W-1:0]         remaining,
    input  fba_pkg::dp_cmd_t                  cmd,
    output fba_pkg::dp_status_t               st
);
    import fba_pkg::*;

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int LIM_W = (CNT_W > BC_W) ? CNT_W : BC_W;
    localparam int CMP_W = (SIZE_WIDTH > AMT_W) ? SIZE_WIDTH : AMT_W;

    // configuration
    logic [MODE_W-1:0]     fit_mode_reg;
    logic [BC_W-1:0]       block_count_reg;

    // captured item
    logic [OP_W-1:0]       op_reg;
    logic [EIDX_W-1:0]     idx_reg;
    logic [AMT_W-1:0]      amount_reg;

    // size table
    logic [SIZE_WIDTH-1:0] mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] vld_reg;

    // scan
    logic [IDX_W-1:0]      addr_reg;
    logic                  rd_pend_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [SIZE_WIDTH-1:0] rd_data_reg;
    logic                  rd_ok_reg;
    logic                  found_reg;
    logic [SIZE_WIDTH-1:0] best_reg;
    logic [IDX_W-1:0]      pick_reg;

    // result
    logic [STAT_W-1:0]     status_reg;
    logic [EIDX_W-1:0]     chosen_reg;
    logic [AMT_W-1:0]      remaining_reg;

    logic [LIM_W-1:0]      nb_w;
    logic [LIM_W-1:0]      bc_w;
    logic [LIM_W-1:0]      limit;
    logic [LIM_W-1:0]      ld_idx_w;
    logic                  ld_in_range;
    logic [IDX_W-1:0]      ld_addr;
    logic [CMP_W-1:0]      amt_w;
    logic [SIZE_WIDTH-1:0] amt_trunc;
    logic [CMP_W-1:0]      stored_w;
    logic [SIZE_WIDTH-1:0] cur;
    logic [CMP_W-1:0]      cur_w;
    logic                  fits;
    logic                  take;
    logic [CMP_W-1:0]      diff_w;
    logic [SIZE_WIDTH-1:0] new_size;
    logic [CMP_W-1:0]      new_w;
    logic [LIM_W-1:0]      pick_w;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [SIZE_WIDTH-1:0] wr_data;

    assign nb_w  = LIM_W'(NUM_BLOCKS);
    assign bc_w  = LIM_W'(block_count_reg);
    assign limit = (bc_w > nb_w) ? nb_w : bc_w;

    assign st.op_in      = op;
    assign st.limit_zero = (limit == '0);
    assign st.addr_last  = ((LIM_W'(addr_reg) + LIM_W'(1)) == limit);

    assign ld_idx_w    = LIM_W'(idx_reg);
    assign ld_in_range = (ld_idx_w < nb_w);
    assign ld_addr     = ld_idx_w[IDX_W-1:0];

    assign amt_w     = CMP_W'(amount_reg);
    assign amt_trunc = amt_w[SIZE_WIDTH-1:0];
    assign stored_w  = CMP_W'(amt_trunc);

    // entries never loaded read as zero
    assign cur   = rd_ok_reg ? rd_data_reg : '0;
    assign cur_w = CMP_W'(cur);
    assign fits  = (cur_w >= amt_w);
    assign take  = rd_pend_reg && fits &&
                   (!found_reg ||
                    (fit_mode_reg == MODE_BEST  && cur < best_reg) ||
                    (fit_mode_reg == MODE_WORST && cur > best_reg));

    assign diff_w   = CMP_W'(best_reg) - amt_w;
    assign new_size = diff_w[SIZE_WIDTH-1:0];
    assign new_w    = CMP_W'(new_size);
    assign pick_w   = LIM_W'(pick_reg);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pick_reg;
        wr_data = new_size;
        if (cmd.finish)
        begin
            if (op_reg == OP_LOAD)
            begin
                wr_en   = ld_in_range;
                wr_addr = ld_addr;
                wr_data = amt_trunc;
            end
            else
            begin
                wr_en = found_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg    <= MODE_FIRST;
            block_count_reg <= BC_RESET;
            vld_reg         <= '0;
            addr_reg        <= '0;
            rd_pend_reg     <= 1'b0;
            found_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FIT_MODE:    fit_mode_reg    <= cfg_data[MODE_W-1:0];
                    CFG_BLOCK_COUNT: block_count_reg <= cfg_data[BC_W-1:0];
                    default:         ;
                endcase
            end
            if (wr_en)
                vld_reg[wr_addr] <= 1'b1;
            rd_pend_reg <= cmd.rd_issue;
            if (cmd.capture)
            begin
                addr_reg  <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.rd_issue)
                    addr_reg <= addr_reg + IDX_W'(1);
                if (take)
                    found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[addr_reg];
            rd_ok_reg   <= vld_reg[addr_reg];
            rd_idx_reg  <= addr_reg;
        end
        if (cmd.capture)
        begin
            op_reg     <= op;
            idx_reg    <= entry_index;
            amount_reg <= amount;
        end
        if (take)
        begin
            best_reg <= cur;
            pick_reg <= rd_idx_reg;
        end
        if (cmd.finish)
        begin
            if (op_reg == OP_LOAD)
            begin
                status_reg    <= STAT_LOADED;
                chosen_reg    <= idx_reg;
                remaining_reg <= ld_in_range ? stored_w[AMT_W-1:0] : '0;
            end
            else if (found_reg)
            begin
                status_reg    <= STAT_ALLOC;
                chosen_reg    <= pick_w[EIDX_W-1:0];
                remaining_reg <= new_w[AMT_W-1:0];
            end
            else
            begin
                status_reg    <= STAT_NOALLOC;
                chosen_reg    <= '0;
                remaining_reg <= '0;
            end
        end
    end

    assign status       = status_reg;
    assign chosen_index = chosen_reg;
    assign remaining    = remaining_reg;

endmodule

// ===== hw/rtl/fit_block_allocator.sv =====
// Channel  Direction  Handshake           Payload
// in       sink       in_valid/in_stall   op, entry_index, amount
// out      source     out_valid/out_stall status, chosen_index, remaining
// cfg      sink       cfg_we              cfg_index, cfg_data
//
// A load goes from its transfer to the finish state, which loads the result register; an allocate
// first scans L = min(block_count, NUM_BLOCKS) table entries, reading one table entry a cycle,
// then passes a drain state; an allocate with L = 0 is timed as a load. The finish state waits,
// and so holds off the next transfer, while a finished result waits behind an earlier one.
// One item at a time; in_stall is low only while the block is idle.
// The result register lets the next item start while a result waits on out_stall.
// Reset clears the whole table (per-entry valid bits) at once, no sweep.
module fit_block_allocator
#(
    parameter int NUM_BLOCKS = fba_pkg::DEF_NUM_BLOCKS,
    parameter int SIZE_WIDTH = fba_pkg::DEF_SIZE_WIDTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fba_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [fba_pkg::OP_W-1:0]       op,
    input  logic [fba_pkg::EIDX_W-1:0]     entry_index,
    input  logic [fba_pkg::AMT_W-1:0]      amount,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [fba_pkg::STAT_W-1:0]     status,
    output logic [fba_pkg::EIDX_W-1:0]     chosen_index,
    output logic [fba_pkg::AMT_W-1:0]      remaining
);
    import fba_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t st;

    fba_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    fba_dp
    #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_WIDTH (SIZE_WIDTH)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .op           (op),
        .entry_index  (entry_index),
        .amount       (amount),
        .status       (status),
        .chosen_index (chosen_index),
        .remaining    (remaining),
        .cmd          (cmd),
        .st           (st)
    );

endmodule
